/* design/cif_pkg.sv */
package cif_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int GEOM_W      = 11;
    localparam int DIM_W       = (GEOM_W > COL_W + 1)
                                 ? ((GEOM_W > ROW_W + 1) ? GEOM_W : ROW_W + 1)
                                 : ((COL_W > ROW_W) ? COL_W + 1 : ROW_W + 1);
    localparam int MIN_DIM     = 3;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam int PIX_W       = 8;
    localparam int TAP_W       = 5;
    localparam int NTAPS       = 9;
    localparam int TAPS_W      = TAP_W * NTAPS;
    localparam int PROD_W      = PIX_W + TAP_W;
    localparam int SUM_W       = PROD_W + 4;

    localparam int DIVISOR     = 9;
    localparam int SAT_LIMIT   = 256 * DIVISOR;
    localparam int QIN_W       = $clog2(SAT_LIMIT);
    localparam int RECIP_SHIFT = 15;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PIX_MAX     = 255;

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = FIFO_AW + 1;

    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_TAPS   = 2'd2
    } cfg_reg_t;

    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic emit;
        logic last;
    } pix_flags_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
    } result_t;

    function automatic logic [DIM_W-1:0] dim_last(input logic [GEOM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] e;
        e = DIM_W'(v);
        if (e < DIM_W'(MIN_DIM))
        begin
            e = DIM_W'(MIN_DIM);
        end
        else if (e > lim)
        begin
            e = lim;
        end
        return e - DIM_W'(1);
    endfunction

    function automatic prod_t mul_tap(input logic [PIX_W-1:0] px,
                                      input logic [TAPS_W-1:0] taps,
                                      input int k);
        logic signed [PIX_W:0]       sp;
        logic signed [TAP_W-1:0]     t;
        logic signed [PIX_W+TAP_W:0] full;
        sp   = $signed({1'b0, px});
        t    = $signed(taps[k*TAP_W +: TAP_W]);
        full = sp * t;
        return prod_t'(full);
    endfunction

endpackage

/* design/cif_window.sv */
module cif_window
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [cif_pkg::PIX_W-1:0]        pixel,
    input  logic                             restart,
    input  logic [cif_pkg::GEOM_W-1:0]       image_width,
    input  logic [cif_pkg::GEOM_W-1:0]       image_height,
    input  logic [cif_pkg::TAPS_W-1:0]       kernel_taps,
    output logic                             s1_valid,
    output logic                             s2_valid,
    output cif_pkg::prod_t                   s2_prod [cif_pkg::NTAPS],
    output cif_pkg::pix_flags_t              s2_flags
);

    logic [cif_pkg::DIM_W-1:0]   wlast_full;
    logic [cif_pkg::DIM_W-1:0]   hlast_full;
    logic [cif_pkg::COL_W-1:0]   wlast;
    logic [cif_pkg::ROW_W-1:0]   hlast;

    logic [cif_pkg::COL_W-1:0]   col_reg;
    logic [cif_pkg::ROW_W-1:0]   row_reg;
    logic [cif_pkg::COL_W-1:0]   col_next;
    logic [cif_pkg::ROW_W-1:0]   row_next;

    logic [2*cif_pkg::PIX_W-1:0] line_mem [cif_pkg::MAX_WIDTH];
    logic [2*cif_pkg::PIX_W-1:0] rd_data_reg;
    logic [2*cif_pkg::PIX_W-1:0] fwd_data_reg;
    logic                        fwd_hit_reg;
    logic [2*cif_pkg::PIX_W-1:0] col_pair;
    logic [2*cif_pkg::PIX_W-1:0] wr_data;

    logic                        s1_valid_reg;
    logic [cif_pkg::PIX_W-1:0]   s1_pixel_reg;
    logic [cif_pkg::COL_W-1:0]   s1_col_reg;
    cif_pkg::pix_flags_t         s1_flags_reg;
    cif_pkg::pix_flags_t         flags_next;

    logic [cif_pkg::PIX_W-1:0]   win_reg [6];
    logic [cif_pkg::PIX_W-1:0]   col_px [3];
    logic [cif_pkg::PIX_W-1:0]   tap_px [cif_pkg::NTAPS];

    logic                        s2_valid_reg;
    cif_pkg::prod_t              s2_prod_reg [cif_pkg::NTAPS];
    cif_pkg::pix_flags_t         s2_flags_reg;

    assign wlast_full = cif_pkg::dim_last(image_width,
                                          cif_pkg::DIM_W'(cif_pkg::MAX_WIDTH));
    assign hlast_full = cif_pkg::dim_last(image_height,
                                          cif_pkg::DIM_W'(cif_pkg::MAX_HEIGHT));
    assign wlast = wlast_full[cif_pkg::COL_W-1:0];
    assign hlast = hlast_full[cif_pkg::ROW_W-1:0];

    always_comb
    begin
        col_next = col_reg + cif_pkg::COL_W'(1);
        row_next = row_reg;
        if (col_reg == wlast)
        begin
            col_next = '0;
            row_next = (row_reg == hlast) ? '0 : row_reg + cif_pkg::ROW_W'(1);
        end
        flags_next.emit = (row_reg >= cif_pkg::ROW_W'(2)) && (col_reg >= cif_pkg::COL_W'(2));
        flags_next.last = (row_reg == hlast) && (col_reg == wlast);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= accept;
            fwd_hit_reg  <= s1_valid_reg && (s1_col_reg == col_reg);
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // The row pair of the column being written this cycle is forwarded when
    // the next read hits the same entry.
    assign col_pair  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign col_px[0] = col_pair[2*cif_pkg::PIX_W-1:cif_pkg::PIX_W];
    assign col_px[1] = col_pair[cif_pkg::PIX_W-1:0];
    assign col_px[2] = s1_pixel_reg;
    assign wr_data   = {col_px[1], s1_pixel_reg};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg  <= line_mem[col_reg];
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_reg;
            s1_flags_reg <= flags_next;
        end
        if (s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[3+i] <= win_reg[i];
                win_reg[i]   <= col_px[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tap_px[3*i]     = win_reg[3+i];
            tap_px[3*i + 1] = win_reg[i];
            tap_px[3*i + 2] = col_px[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int k = 0; k < cif_pkg::NTAPS; k++)
            begin
                s2_prod_reg[k] <= cif_pkg::mul_tap(tap_px[k], kernel_taps, k);
            end
            s2_flags_reg <= s1_flags_reg;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s2_valid = s2_valid_reg;
    assign s2_prod  = s2_prod_reg;
    assign s2_flags = s2_flags_reg;

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= wlast)
        else $error("column counter beyond the row width");

    a_last_is_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_flags_reg.last) |-> s1_flags_reg.emit)
        else $error("last flag on a border pixel");
`endif

endmodule

/* design/cif_math.sv */
module cif_math
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s2_valid,
    input  cif_pkg::prod_t              s2_prod [cif_pkg::NTAPS],
    input  cif_pkg::pix_flags_t         s2_flags,
    output logic                        s3_valid,
    output logic                        push,
    output cif_pkg::result_t            result
);

    logic signed [cif_pkg::SUM_W-1:0]               sum_next;
    logic signed [cif_pkg::SUM_W-1:0]               sum_reg;
    logic                                           s3_valid_reg;
    cif_pkg::pix_flags_t                            s3_flags_reg;
    logic [cif_pkg::QIN_W-1:0]                      q_in;
    logic [cif_pkg::QIN_W+cif_pkg::RECIP_W-1:0]     q_prod;

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < cif_pkg::NTAPS; k++)
        begin
            sum_next = sum_next + cif_pkg::SUM_W'(s2_prod[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid)
        begin
            sum_reg      <= sum_next;
            s3_flags_reg <= s2_flags;
        end
    end

    // Below the saturation limit the quotient by nine is exact through the
    // scaled reciprocal.
    assign q_in   = sum_reg[cif_pkg::QIN_W-1:0];
    assign q_prod = (cif_pkg::QIN_W+cif_pkg::RECIP_W)'(q_in)
                    * (cif_pkg::QIN_W+cif_pkg::RECIP_W)'(cif_pkg::RECIP);

    always_comb
    begin
        if (sum_reg < 0)
        begin
            result.value = '0;
        end
        else if (sum_reg >= cif_pkg::SUM_W'(cif_pkg::SAT_LIMIT))
        begin
            result.value = cif_pkg::PIX_W'(cif_pkg::PIX_MAX);
        end
        else
        begin
            result.value = q_prod[cif_pkg::RECIP_SHIFT +: cif_pkg::PIX_W];
        end
        result.last = s3_flags_reg.last;
    end

    assign push     = s3_valid_reg && s3_flags_reg.emit;
    assign s3_valid = s3_valid_reg;

endmodule

/* design/cif_out_fifo.sv */
module cif_out_fifo
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  cif_pkg::result_t              wr_word,
    input  logic                          rd_stall,
    output logic                          rd_valid,
    output cif_pkg::result_t              rd_word,
    output logic [cif_pkg::FIFO_CW-1:0]   count
);

    cif_pkg::result_t                   fifo_mem [cif_pkg::FIFO_DEPTH];
    logic [cif_pkg::FIFO_AW-1:0]        wr_ptr_reg;
    logic [cif_pkg::FIFO_AW-1:0]        rd_ptr_reg;
    logic [cif_pkg::FIFO_CW-1:0]        count_reg;
    logic                               pop;

    assign rd_valid = (count_reg != '0);
    assign pop      = rd_valid && !rd_stall;
    assign rd_word  = fifo_mem[rd_ptr_reg];
    assign count    = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + cif_pkg::FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + cif_pkg::FIFO_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + cif_pkg::FIFO_CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - cif_pkg::FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= wr_word;
        end
    end

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cif_pkg::FIFO_CW'(cif_pkg::FIFO_DEPTH))
        else $error("output queue overflow");
`endif

endmodule

/* design/conv3x3_image_filter.sv */
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------
// input    | pixel_valid / pixel_stall  | pixel
// output   | result_valid / result_stall| out_pixel, last
// config   | cfg_write                  | cfg_index, cfg_data
//
// One pixel is taken per cycle while pixel_stall is low; a result passes
// through the line memory read, the tap products, the sum and the divide.
// The single line memory is read and written once per pixel, which sets the
// rate of one word per cycle while neither side stalls.
// Reset clears the counters, the window and the output queue; the line
// memory keeps whatever it holds.
// Input stalls only when the output queue plus the words in flight fill its
// eight entries.
module conv3x3_image_filter
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  logic [cif_pkg::PIX_W-1:0]          pixel,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [cif_pkg::PIX_W-1:0]          out_pixel,
    output logic                               last,
    input  logic                               cfg_write,
    input  logic [cif_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cif_pkg::TAPS_W-1:0]         cfg_data
);

    logic [cif_pkg::GEOM_W-1:0]   width_reg;
    logic [cif_pkg::GEOM_W-1:0]   height_reg;
    logic [cif_pkg::TAPS_W-1:0]   taps_reg;
    logic                         restart;
    logic                         accept;

    logic                         s1_valid;
    logic                         s2_valid;
    logic                         s3_valid;
    cif_pkg::prod_t               s2_prod [cif_pkg::NTAPS];
    cif_pkg::pix_flags_t          s2_flags;
    logic                         push;
    cif_pkg::result_t             result;
    cif_pkg::result_t             rd_word;
    logic [cif_pkg::FIFO_CW-1:0]  fifo_count;
    logic [cif_pkg::FIFO_CW:0]    pending;

    assign restart = cfg_write && ((cif_pkg::cfg_reg_t'(cfg_index) == cif_pkg::REG_WIDTH)
                     || (cif_pkg::cfg_reg_t'(cfg_index) == cif_pkg::REG_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cif_pkg::GEOM_W'(cif_pkg::WIDTH_RESET);
            height_reg <= cif_pkg::GEOM_W'(cif_pkg::HEIGHT_RESET);
            taps_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cif_pkg::cfg_reg_t'(cfg_index))
                cif_pkg::REG_WIDTH:  width_reg  <= cfg_data[cif_pkg::GEOM_W-1:0];
                cif_pkg::REG_HEIGHT: height_reg <= cfg_data[cif_pkg::GEOM_W-1:0];
                cif_pkg::REG_TAPS:   taps_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign pending = (cif_pkg::FIFO_CW+1)'(s1_valid) + (cif_pkg::FIFO_CW+1)'(s2_valid)
                     + (cif_pkg::FIFO_CW+1)'(s3_valid) + (cif_pkg::FIFO_CW+1)'(fifo_count);
    assign pixel_stall = (pending >= (cif_pkg::FIFO_CW+1)'(cif_pkg::FIFO_DEPTH));
    assign accept      = pixel_valid && !pixel_stall;

    cif_window u_window
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pixel        (pixel),
        .restart      (restart),
        .image_width  (width_reg),
        .image_height (height_reg),
        .kernel_taps  (taps_reg),
        .s1_valid     (s1_valid),
        .s2_valid     (s2_valid),
        .s2_prod      (s2_prod),
        .s2_flags     (s2_flags)
    );

    cif_math u_math
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s2_valid (s2_valid),
        .s2_prod  (s2_prod),
        .s2_flags (s2_flags),
        .s3_valid (s3_valid),
        .push     (push),
        .result   (result)
    );

    cif_out_fifo u_out_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_word  (result),
        .rd_stall (result_stall),
        .rd_valid (result_valid),
        .rd_word  (rd_word),
        .count    (fifo_count)
    );

    assign out_pixel = rd_word.value;
    assign last      = rd_word.last;

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending <= (cif_pkg::FIFO_CW+1)'(cif_pkg::FIFO_DEPTH))
        else $error("more words in flight than the output queue can hold");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    import cif_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PIXELS = 800;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pixel_valid = 1'b0;
    logic                 pixel_stall;
    logic [PIX_W-1:0]     pixel = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [PIX_W-1:0]     out_pixel;
    logic                 last;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TAPS_W-1:0]    cfg_data = '0;

    logic [PIX_W-1:0] pixels_to_send[$];
    result_t          filtered_q[$];
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               err_count = 0;

    // Shadow copy of the filter state.
    logic [GEOM_W-1:0] width_reg;
    logic [GEOM_W-1:0] height_reg;
    logic [TAPS_W-1:0] taps_reg;
    logic [PIX_W-1:0]  line_mem[2][MAX_WIDTH];
    logic [PIX_W-1:0]  win[6];
    int unsigned       col_pos;
    int unsigned       row_pos;

    conv3x3_image_filter uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_pixel    (out_pixel),
        .last         (last),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int unsigned eff_dim(input logic [GEOM_W-1:0] v, input int unsigned lim);
        if (v < MIN_DIM)
        begin
            return MIN_DIM;
        end
        if (v > lim)
        begin
            return lim;
        end
        return 32'(v);
    endfunction

    function automatic int tap_at(input int k);
        logic signed [TAP_W-1:0] t;
        t = taps_reg[k*TAP_W +: TAP_W];
        return t;
    endfunction

    function automatic void filter_pixel(input logic [PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        logic [PIX_W-1:0] colv[3];
        int               acc;
        int               q;
        result_t          res;
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        colv[0] = line_mem[1][col_pos];
        colv[1] = line_mem[0][col_pos];
        colv[2] = pix;
        if (row_pos >= 2 && col_pos >= 2)
        begin
            acc = 0;
            for (int i = 0; i < 3; i++)
            begin
                acc += int'(win[3+i]) * tap_at(3*i);
                acc += int'(win[i]) * tap_at(3*i + 1);
                acc += int'(colv[i]) * tap_at(3*i + 2);
            end
            q = acc / DIVISOR;
            if (q < 0)
            begin
                q = 0;
            end
            if (q > PIX_MAX)
            begin
                q = PIX_MAX;
            end
            res.value = q[PIX_W-1:0];
            res.last = (row_pos == h - 1) && (col_pos == w - 1);
            filtered_q.push_back(res);
        end
        line_mem[1][col_pos] = colv[1];
        line_mem[0][col_pos] = pix;
        for (int i = 0; i < 3; i++)
        begin
            win[3+i] = win[i];
            win[i] = colv[i];
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
            begin
                row_pos = 0;
            end
        end
    endfunction

    function automatic logic [TAPS_W-1:0] with_junk(input logic [GEOM_W-1:0] v);
        logic [TAPS_W-1:0] d;
        d = TAPS_W'({$urandom, $urandom});
        d[GEOM_W-1:0] = v;
        return d;
    endfunction

    function automatic logic [TAPS_W-1:0] pick_taps();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return {NTAPS{5'h0F}};
            default: return TAPS_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        $display("[%0t] error: %s", $time, msg);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TAPS_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_WIDTH:
            begin
                width_reg = data[GEOM_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            REG_HEIGHT:
            begin
                height_reg = data[GEOM_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            REG_TAPS:
            begin
                taps_reg = data;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_idle();
        while (pixels_to_send.size() != 0 || pixel_valid || filtered_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_pixels(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                pixels_to_send.push_back($urandom_range(1) ? 8'hFF : 8'h00);
            end
            else
            begin
                pixels_to_send.push_back(PIX_W'($urandom));
            end
        end
    endtask

    task automatic set_idling(input int m);
        case (m)
            0:
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 48;
                stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct = 48;
            end
            default:
            begin
                send_idle_pct = 37;
                stall_pct = 37;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel <= '0;
        end
        else if (!pixel_valid || !pixel_stall)
        begin
            if (pixel_valid)
            begin
                filter_pixel(pixel);
            end
            if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pixel_valid <= 1'b1;
                pixel <= pixels_to_send.pop_front();
            end
            else
            begin
                pixel_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (filtered_q.size() == 0)
                begin
                    note_error($sformatf("unexpected word out_pixel=%0d last=%0b",
                                         out_pixel, last));
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (out_pixel !== want.value)
                    begin
                        note_error($sformatf("out_pixel %0d, wanted %0d", out_pixel, want.value));
                    end
                    if (last !== want.last)
                    begin
                        note_error($sformatf("last %0b, wanted %0b", last, want.last));
                    end
                end
            end
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int n;
        int sent;
        int ph;
        int wide;
        width_reg = GEOM_W'(WIDTH_RESET);
        height_reg = GEOM_W'(HEIGHT_RESET);
        taps_reg = '0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            line_mem[0][i] = '0;
            line_mem[1][i] = '0;
        end
        for (int i = 0; i < 6; i++)
        begin
            win[i] = '0;
        end
        col_pos = 0;
        row_pos = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Smallest frame: full positive and full negative saturation, a kernel
        // change in the middle of a frame, and an ignored register index.
        write_reg(REG_WIDTH, '0);
        write_reg(REG_HEIGHT, TAPS_W'(1));
        write_reg(REG_TAPS, {NTAPS{5'd15}});
        repeat (9) pixels_to_send.push_back(8'hFF);
        wait_idle();
        write_reg(REG_TAPS, TAPS_W'(9) << (4*TAP_W));
        pixels_to_send.push_back(8'h00);
        pixels_to_send.push_back(8'h80);
        pixels_to_send.push_back(8'h01);
        pixels_to_send.push_back(8'hFE);
        wait_idle();
        write_reg(REG_TAPS, {NTAPS{5'h10}});
        repeat (5) pixels_to_send.push_back(8'hFF);
        wait_idle();
        write_reg(REG_NONE, '1);
        write_reg(REG_HEIGHT, TAPS_W'(2));
        write_reg(REG_TAPS, TAPS_W'(9) << (4*TAP_W));
        repeat (7) pixels_to_send.push_back(PIX_W'($urandom));
        wait_idle();

        // A wide frame run to its end.
        set_idling(3);
        wide = $urandom_range(250, 300);
        write_reg(REG_WIDTH, with_junk(GEOM_W'(wide)));
        write_reg(REG_HEIGHT, with_junk(GEOM_W'(3)));
        write_reg(REG_TAPS, pick_taps());
        queue_pixels(3 * wide);
        wait_idle();

        sent = 0;
        ph = 0;
        while (sent < RANDOM_PIXELS)
        begin
            set_idling(ph % 4);
            if ($urandom_range(9) == 0)
            begin
                write_reg(REG_WIDTH, with_junk(GEOM_W'($urandom_range(2))));
            end
            else
            begin
                write_reg(REG_WIDTH, with_junk(GEOM_W'($urandom_range(3, 16))));
            end
            if ($urandom_range(9) == 0)
            begin
                write_reg(REG_HEIGHT, with_junk(GEOM_W'($urandom_range(2))));
            end
            else
            begin
                write_reg(REG_HEIGHT, with_junk(GEOM_W'($urandom_range(3, 8))));
            end
            write_reg(REG_TAPS, pick_taps());
            if ($urandom_range(3) == 0)
            begin
                write_reg(REG_NONE, TAPS_W'({$urandom, $urandom}));
            end
            n = $urandom_range(60, 200);
            queue_pixels(n / 2);
            wait_idle();
            write_reg(REG_TAPS, pick_taps());
            queue_pixels(n - n / 2);
            wait_idle();
            sent += n;
            ph++;
        end

        if (err_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
